// ===== rtl/wsfu_pkg.sv =====
// ---------------------------------------------------------------------------
// wsfu_pkg: shared types and constants for the frame unmasker
// Payload structs for both channels, header codes and frame class codes.
// ---------------------------------------------------------------------------
package wsfu_pkg;

    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_MASK   = 4'hF;
    localparam logic [6:0] LEN_MASK  = 7'h7F;
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    localparam logic [1:0] CLS_TEXT  = 2'd0;
    localparam logic [1:0] CLS_CLOSE = 2'd1;
    localparam logic [1:0] CLS_OTHER = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_payload;
        logic [1:0] frame_class;
        logic       echo_ok;
        logic       length_error;
        logic       last;
    } t_out_item;

endpackage

// ===== rtl/wsfu_parser.sv =====
// ---------------------------------------------------------------------------
// wsfu_parser: header parser and payload unmask
// Holds the parse state of the current frame and forms the result for the
// item at its input; the state advances when the item moves on.
// ---------------------------------------------------------------------------
module wsfu_parser
    import wsfu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_item  i_item,
    output t_out_item o_result
);

    typedef enum logic [3:0] {
        PH_HDR0    = 4'd0,
        PH_HDR1    = 4'd1,
        PH_EXT_HI  = 4'd2,
        PH_EXT_LO  = 4'd3,
        PH_MASK0   = 4'd4,
        PH_MASK1   = 4'd5,
        PH_MASK2   = 4'd6,
        PH_MASK3   = 4'd7,
        PH_PAYLOAD = 4'd8,
        PH_TRAIL   = 4'd9,
        PH_DROP    = 4'd10
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [3:0]  r_opcode, n_opcode;
    logic [15:0] r_length, n_length;
    logic [15:0] r_index,  n_index;
    logic [31:0] r_key,    n_key;
    logic        r_error,  n_error;

    logic [7:0]  out_byte;
    logic        is_payload;
    logic [1:0]  frame_class;
    logic [6:0]  len7;
    logic [7:0]  key_byte;

    assign len7 = i_item.in_byte[6:0] & LEN_MASK;

    always_comb begin
        unique case (r_index[1:0])
            2'd0:    key_byte = r_key[7:0];
            2'd1:    key_byte = r_key[15:8];
            2'd2:    key_byte = r_key[23:16];
            default: key_byte = r_key[31:24];
        endcase
    end

    always_comb begin
        n_phase    = r_phase;
        n_opcode   = r_opcode;
        n_length   = r_length;
        n_index    = r_index;
        n_key      = r_key;
        n_error    = r_error;
        out_byte   = i_item.in_byte;
        is_payload = 1'b0;

        unique case (r_phase)
            PH_HDR0: begin
                n_opcode = i_item.in_byte[3:0] & OP_MASK;
                n_phase  = PH_HDR1;
            end
            PH_HDR1: begin
                if (len7 == LEN_EXT16) begin
                    n_phase = PH_EXT_HI;
                end else if (len7 == LEN_EXT64) begin
                    n_error = 1'b1;
                    n_phase = PH_DROP;
                end else begin
                    n_length = {9'd0, len7};
                    n_phase  = PH_MASK0;
                end
            end
            PH_EXT_HI: begin
                n_length = {i_item.in_byte, 8'd0};
                n_phase  = PH_EXT_LO;
            end
            PH_EXT_LO: begin
                n_length = {r_length[15:8], i_item.in_byte};
                n_phase  = PH_MASK0;
            end
            PH_MASK0: begin
                n_key[7:0] = i_item.in_byte;
                n_phase    = PH_MASK1;
            end
            PH_MASK1: begin
                n_key[15:8] = i_item.in_byte;
                n_phase     = PH_MASK2;
            end
            PH_MASK2: begin
                n_key[23:16] = i_item.in_byte;
                n_phase      = PH_MASK3;
            end
            PH_MASK3: begin
                n_key[31:24] = i_item.in_byte;
                n_index      = 16'd0;
                n_phase      = (r_length == 16'd0) ? PH_TRAIL : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                out_byte   = i_item.in_byte ^ key_byte;
                is_payload = 1'b1;
                n_index    = r_index + 16'd1;
                if (n_index >= r_length) begin
                    n_phase = PH_TRAIL;
                end
            end
            default: begin
                // trailing bytes, dropped frame and unused codes pass raw
            end
        endcase

        if (n_opcode == OP_TEXT) begin
            frame_class = CLS_TEXT;
        end else if (n_opcode == OP_CLOSE) begin
            frame_class = CLS_CLOSE;
        end else begin
            frame_class = CLS_OTHER;
        end

        o_result.out_byte     = out_byte;
        o_result.is_payload   = is_payload;
        o_result.frame_class  = frame_class;
        o_result.echo_ok      = (frame_class != CLS_CLOSE) && !n_error;
        o_result.length_error = n_error;
        o_result.last         = i_item.end_of_buffer;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_HDR0;
            r_opcode <= '0;
            r_length <= '0;
            r_index  <= '0;
            r_key    <= '0;
            r_error  <= 1'b0;
        end else if (i_advance) begin
            if (i_item.end_of_buffer) begin
                // restart the parser for the next buffer
                r_phase  <= PH_HDR0;
                r_opcode <= '0;
                r_length <= '0;
                r_index  <= '0;
                r_key    <= '0;
                r_error  <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_opcode <= n_opcode;
                r_length <= n_length;
                r_index  <= n_index;
                r_key    <= n_key;
                r_error  <= n_error;
            end
        end
    end

endmodule

// ===== rtl/wsfu_out_reg.sv =====
// ---------------------------------------------------------------------------
// wsfu_out_reg: result register
// Holds one result until the consumer takes it; reloads in the same cycle.
// ---------------------------------------------------------------------------
module wsfu_out_reg
    import wsfu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_out_item i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic      r_valid;
    t_out_item r_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_data;
        end
    end

endmodule

// ===== rtl/websocket_frame_unmasker_unit.sv =====
// ---------------------------------------------------------------------------
// websocket_frame_unmasker_unit: frame header parser and payload unmasker
// Each byte passes the input register, then the result register. Throughput:
// one byte per cycle while the output is not stalled, set by the single parse
// step between the two registers. Reset is synchronous, active low, and
// returns the parser to the first header byte with both stages empty.
// ---------------------------------------------------------------------------
module websocket_frame_unmasker_unit
    import wsfu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      out_ready;
    logic      advance;
    t_out_item result;

    assign advance    = r_in_valid && out_ready;
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // hold the byte while the result stage is stalled
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_data;
        end
    end

    wsfu_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_result  (result)
    );

    wsfu_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_valid),
        .o_ready (out_ready),
        .i_data  (result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

// ===== rtl/wsfu_checker.sv =====
// ---------------------------------------------------------------------------
// wsfu_checker: port-level checks for the frame unmasker
// Watches the top-level ports; flags results that break the frame rules or handshake.
// ---------------------------------------------------------------------------
module wsfu_checker
    import wsfu_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    // a dropped frame is never echoed
    a_err_no_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.length_error |-> !o_out_data.echo_ok)
        else $error("echo flagged on a frame with a length error");

    // no unmasking inside a dropped frame
    a_err_no_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_payload |-> !o_out_data.length_error)
        else $error("payload byte in a dropped frame");

    // close frames are never echoed
    a_close_no_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.frame_class == CLS_CLOSE |-> !o_out_data.echo_ok)
        else $error("echo flagged on a close frame");

    // a result cannot appear from drained stages without an input transfer
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && $past(!o_out_valid) && !(i_in_valid && o_in_ready)
            && $past(!(i_in_valid && o_in_ready)) |=> !o_out_valid)
        else $error("result appeared without an input transfer");

endmodule

bind websocket_frame_unmasker_unit wsfu_checker u_wsfu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
